@@ rtl/core/ip_acl_first_match_macros.svh @@
// Assertion helpers for the access filter; all sample on clk, idle in reset.
`ifndef IP_ACL_FIRST_MATCH_MACROS_SVH
`define IP_ACL_FIRST_MATCH_MACROS_SVH

// Same-cycle implication.
`define IPACL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipacl: check failed");

// Next-cycle implication.
`define IPACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipacl: check failed");

`endif

@@ rtl/core/ipacl_pkg.sv @@
package ipacl_pkg;

  localparam int RULE_ENTRIES = 16;
  localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;

  localparam int ADDR_W    = 32;
  localparam int RIDX_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = COUNT_W;

  // widths for index compares against the fixed-width fields
  localparam int SEL_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
  localparam int LIM_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ALLOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT     = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
    logic              address_valid;
    logic [RIDX_W-1:0] rule_index;
    logic [ADDR_W-1:0] rule_mask;
    logic              rule_allow;
  } acl_in_t;

  typedef struct packed {
    logic              allowed;
    logic              rule_hit;
    logic [RIDX_W-1:0] hit_index;
  } acl_out_t;

  // one beat as it moves down the cell chain
  typedef struct packed {
    acl_in_t          req;
    logic             hit;
    logic [IDX_W-1:0] hit_at;
    logic             verdict;
  } cell_item_t;

  typedef struct packed {
    logic               advance;
    logic [COUNT_W-1:0] rule_count;
  } cell_ctrl_t;

endpackage

@@ rtl/core/ipacl_cell.sv @@
module ipacl_cell import ipacl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             valid_in,
  input  cell_item_t       item_in,
  output logic             valid_out,
  output cell_item_t       item_out
);

  logic [ADDR_W-1:0] rule_addr_r;
  logic [ADDR_W-1:0] rule_mask_r;
  logic              rule_allow_r;
  logic              valid_r;
  cell_item_t        item_r;
  cell_item_t        item_nxt;
  logic              sel_write;
  logic              active;
  logic              match;

  assign sel_write = valid_in && (item_in.req.cmd == CMD_WRITE) &&
                     (SEL_W'(item_in.req.rule_index) == SEL_W'(cell_idx));
  assign active    = LIM_W'(cell_idx) < LIM_W'(ctrl.rule_count);
  assign match     = (item_in.req.address & rule_mask_r) == rule_addr_r;

  always_comb begin
    item_nxt = item_in;
    // first match wins: earlier cells already set hit
    if (item_in.req.cmd == CMD_LOOKUP && item_in.req.address_valid &&
        !item_in.hit && active && match) begin
      item_nxt.hit     = 1'b1;
      item_nxt.hit_at  = cell_idx;
      item_nxt.verdict = rule_allow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      item_r <= item_nxt;
      if (sel_write) begin
        rule_addr_r  <= item_in.req.address;
        rule_mask_r  <= item_in.req.rule_mask;
        rule_allow_r <= item_in.req.rule_allow;
      end
    end
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;

endmodule

@@ rtl/core/ip_acl_first_match.sv @@
// Throughput: one beat per cycle while the chain is not frozen (see below).
// Rule writes and lookups share the cell chain in order.
// Beats pass through the chain of rule cells, one stage per rule, plus the output register.
// The chain freezes only while a result sits in the output register and out_stall is high.
// Reset clears the configuration registers and all stage valids; rule cells keep old contents.
`include "ip_acl_first_match_macros.svh"
module ip_acl_first_match import ipacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acl_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output acl_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic               filter_en_r;
  logic               default_allow_r;
  logic [COUNT_W-1:0] rule_count_r;
  logic               out_valid_r;
  acl_out_t           out_r;
  acl_out_t           out_nxt;
  cell_ctrl_t         ctrl;
  cell_item_t         head;
  logic               advance;

  logic       chain_valid [RULE_ENTRIES+1];
  cell_item_t chain_item  [RULE_ENTRIES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r     <= 1'b0;
      default_allow_r <= 1'b0;
      rule_count_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLED: filter_en_r     <= cfg_data[0];
        CFG_DEFAULT_ALLOW:  default_allow_r <= cfg_data[0];
        CFG_RULE_COUNT:     rule_count_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  assign ctrl.advance    = advance;
  assign ctrl.rule_count = rule_count_r;

  always_comb begin
    head         = '0;
    head.req     = in_data;
    head.verdict = default_allow_r;
  end

  assign chain_valid[0] = in_valid;
  assign chain_item[0]  = head;

  for (genvar g = 0; g < RULE_ENTRIES; g++) begin : g_cell
    ipacl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(g)),
      .valid_in  (chain_valid[g]),
      .item_in   (chain_item[g]),
      .valid_out (chain_valid[g+1]),
      .item_out  (chain_item[g+1])
    );
  end

  always_comb begin
    out_nxt = '0;
    if (filter_en_r) begin
      out_nxt.allowed = chain_item[RULE_ENTRIES].verdict;
      if (chain_item[RULE_ENTRIES].hit) begin
        out_nxt.rule_hit  = 1'b1;
        out_nxt.hit_index = RIDX_W'(chain_item[RULE_ENTRIES].hit_at);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain_valid[RULE_ENTRIES] &&
                     (chain_item[RULE_ENTRIES].req.cmd == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IPACL_ASSERT_NOW(a_hit_needs_enable, out_valid_r && out_r.rule_hit, filter_en_r)
  `IPACL_ASSERT_NOW(a_no_hit_zero_index, out_valid_r && !out_r.rule_hit, out_r.hit_index == '0)
  `IPACL_ASSERT_NOW(a_disabled_denies, out_valid_r && !filter_en_r, !out_r.allowed)
  `IPACL_ASSERT_NEXT(a_held_result_kept, out_valid_r && out_stall, out_valid_r && $stable(out_r))

endmodule

@@ tb/sv/tb_ip_acl_first_match.sv @@
module tb_ip_acl_first_match;
  import ipacl_pkg::*;

  localparam int DRAIN_CYCLES    = RULE_ENTRIES + 9;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_BEATS     = 220;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  acl_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  acl_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ip_acl_first_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the rule table and registers
  logic [ADDR_W-1:0]  acl_addr_tbl [RULE_ENTRIES];
  logic [ADDR_W-1:0]  acl_mask_tbl [RULE_ENTRIES];
  logic               acl_allow_tbl [RULE_ENTRIES];
  logic               filt_en = 1'b0;
  logic               dflt_allow = 1'b0;
  logic [COUNT_W-1:0] rule_cnt = '0;

  acl_out_t verdict_q[$];
  int       bad_verdicts = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 25;
  int       recv_idle_pct = 25;
  bit       hold_req = 1'b0;

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  function automatic acl_out_t predict_verdict(acl_in_t beat);
    acl_out_t res;
    int lim;
    res = '0;
    if (!filt_en) return res;
    res.allowed = dflt_allow;
    if (!beat.address_valid) return res;
    lim = (rule_cnt > RULE_ENTRIES) ? RULE_ENTRIES : int'(rule_cnt);
    for (int i = 0; i < lim; i++) begin
      if ((beat.address & acl_mask_tbl[IDX_W'(i)]) == acl_addr_tbl[IDX_W'(i)]) begin
        res.allowed   = acl_allow_tbl[IDX_W'(i)];
        res.rule_hit  = 1'b1;
        res.hit_index = RIDX_W'(i);
        return res;
      end
    end
    return res;
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // one beat, with a random gap ahead of it; the shadow state moves on acceptance
  task automatic send_beat(input acl_in_t beat);
    int gap;
    gap = pick_gap(send_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    if (beat.cmd == CMD_WRITE) begin
      if (beat.rule_index < RULE_ENTRIES) begin
        acl_addr_tbl[beat.rule_index]  = beat.address;
        acl_mask_tbl[beat.rule_index]  = beat.rule_mask;
        acl_allow_tbl[beat.rule_index] = beat.rule_allow;
      end
    end else begin
      verdict_q.push_back(predict_verdict(beat));
    end
  endtask

  task automatic send_rule(input int idx, input logic [ADDR_W-1:0] addr,
                           input logic [ADDR_W-1:0] mask, input logic allow);
    acl_in_t beat;
    beat.cmd           = CMD_WRITE;
    beat.address       = addr;
    beat.address_valid = 1'($urandom_range(1));
    beat.rule_index    = RIDX_W'(idx);
    beat.rule_mask     = mask;
    beat.rule_allow    = allow;
    send_beat(beat);
  endtask

  task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic valid);
    acl_in_t beat;
    beat.cmd           = CMD_LOOKUP;
    beat.address       = addr;
    beat.address_valid = valid;
    beat.rule_index    = RIDX_W'($urandom_range(15));
    beat.rule_mask     = $urandom;
    beat.rule_allow    = 1'($urandom_range(1));
    send_beat(beat);
  endtask

  // wait for every lookup to come back, then let trailing rule writes leave the chain
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_ENABLED: filt_en = val[0];
      CFG_DEFAULT_ALLOW:  dflt_allow = val[0];
      CFG_RULE_COUNT:     rule_cnt = val;
      default: ;
    endcase
  endtask

  // upper data bits of the one-bit registers are junk on purpose
  task automatic set_filter(input logic en, input logic dflt, input int cnt);
    logic [CFG_W-1:0] v;
    drain_pipe();
    v = CFG_W'($urandom);
    v[0] = en;
    write_reg(CFG_FILTER_ENABLED, v);
    v = CFG_W'($urandom);
    v[0] = dflt;
    write_reg(CFG_DEFAULT_ALLOW, v);
    write_reg(CFG_RULE_COUNT, CFG_W'(cnt));
  endtask

  function automatic acl_in_t next_random_beat();
    acl_in_t b;
    int k;
    logic [IDX_W-1:0] e;
    b.address       = $urandom;
    b.rule_mask     = $urandom;
    b.rule_index    = RIDX_W'($urandom_range(15));
    b.address_valid = 1'($urandom_range(1));
    b.rule_allow    = 1'($urandom_range(1));
    k = $urandom_range(99);
    if ($urandom_range(99) < 15) begin
      b.cmd = CMD_WRITE;
      if (k < 70) begin
        b.rule_mask = prefix_mask($urandom_range(32, 8));
        b.address   = b.address & b.rule_mask;
      end else if (k < 80) begin
        b.address = b.address & b.rule_mask;
      end else if (k < 90) begin
        // address not masked: any stray bit set outside the mask keeps the rule from matching
        b.rule_mask = prefix_mask($urandom_range(31, 8));
      end else begin
        b.rule_mask = prefix_mask($urandom_range(7));
        b.address   = b.address & b.rule_mask;
      end
    end else begin
      b.cmd = CMD_LOOKUP;
      b.address_valid = (k >= 8);
      if (k >= 8 && k < 70) begin
        e = IDX_W'($urandom_range(RULE_ENTRIES - 1));
        b.address = (acl_addr_tbl[e] & acl_mask_tbl[e]) | (b.address & ~acl_mask_tbl[e]);
      end
    end
    return b;
  endfunction

  task automatic test_reset_state();
    send_lookup(32'h0A00_0001, 1'b1);
    send_lookup(32'hFFFF_FFFF, 1'b0);
  endtask

  // every entry gets written here, so later scans never touch stale cells
  task automatic test_load_table();
    send_rule(0, 32'h0A00_0001, prefix_mask(32), 1'b0);
    send_rule(1, 32'h0A00_0000, prefix_mask(8), 1'b1);
    send_rule(2, 32'hC0A8_0000, prefix_mask(16), 1'b0);
    send_rule(3, 32'hFFFF_FFFF, prefix_mask(32), 1'b1);
    send_rule(4, 32'h0000_0000, prefix_mask(32), 1'b1);
    send_rule(5, 32'hAC10_0001, prefix_mask(16), 1'b1);
    send_rule(6, 32'hAC10_0000, prefix_mask(16), 1'b0);
    for (int i = 7; i < RULE_ENTRIES - 1; i++)
      send_rule(i, 32'h6440_0000 | (i << 8), prefix_mask(24), i[0]);
    send_rule(RULE_ENTRIES - 1, 32'h0, 32'h0, 1'b1);
  endtask

  task automatic test_first_match();
    set_filter(1'b1, 1'b0, RULE_ENTRIES);
    send_lookup(32'h0A00_0001, 1'b1);
    send_lookup(32'hC0A8_0101, 1'b1);
    send_lookup(32'hFFFF_FFFF, 1'b1);
    send_lookup(32'h0000_0000, 1'b1);
    send_lookup(32'hAC10_0001, 1'b1);
    send_lookup(32'h0A00_0001, 1'b0);
  endtask

  task automatic test_count_limits();
    set_filter(1'b1, 1'b0, RULE_ENTRIES - 2);
    send_lookup(32'h0808_0808, 1'b1);
    set_filter(1'b1, 1'b1, 31);
    send_lookup(32'h0808_0808, 1'b1);
    set_filter(1'b1, 1'b1, 0);
    send_lookup(32'h0A00_0001, 1'b1);
    set_filter(1'b0, 1'b1, RULE_ENTRIES);
    send_lookup(32'h0A00_0001, 1'b1);
  endtask

  // rule write followed at once by a lookup that needs it
  task automatic test_write_then_lookup();
    set_filter(1'b1, 1'b0, RULE_ENTRIES);
    send_idle_pct = 0;
    send_rule(0, 32'h0A00_0001, prefix_mask(32), 1'b1);
    send_lookup(32'h0A00_0001, 1'b1);
    send_idle_pct = 25;
  endtask

  task automatic test_random_sweep();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_filter(1'b1, 1'b0, RULE_ENTRIES);
        1: set_filter(1'b1, 1'b1, RULE_ENTRIES);
        2: set_filter(1'b1, 1'b1, 0);
        3: set_filter(1'b1, 1'b0, 31);
        4: set_filter(1'b0, 1'b1, RULE_ENTRIES);
        5: set_filter(1'b1, 1'b1, 1);
        6: set_filter($urandom_range(3) != 0, 1'($urandom_range(1)), $urandom_range(31));
        default: set_filter(1'b1, 1'b0, $urandom_range(15, 2));
      endcase
      send_idle_pct = (p == 1 || p == 2) ? 0 : 25;
      recv_idle_pct = (p == 1) ? 0 : (p == 2) ? 40 : 25;
      repeat (PHASE_BEATS) send_beat(next_random_beat());
    end
    send_idle_pct = 25;
    recv_idle_pct = 25;
  endtask

  task automatic test_back_pressure();
    set_filter(1'b1, 1'b1, RULE_ENTRIES);
    send_idle_pct = 0;
    hold_req = 1'b1;
    repeat (120) send_beat(next_random_beat());
    send_idle_pct = 25;
  endtask

  // result side stall pattern; a hold request freezes it for a long stretch
  initial begin : drive_out_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left == 0 && $urandom_range(99) < recv_idle_pct)
        stall_left = pick_gap(100);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    acl_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no lookup pending");
        bad_verdicts++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.allowed !== want.allowed) begin
          $error("allowed: expected %0d, got %0d", want.allowed, out_data.allowed);
          bad_verdicts++;
        end
        if (out_data.rule_hit !== want.rule_hit) begin
          $error("rule_hit: expected %0d, got %0d", want.rule_hit, out_data.rule_hit);
          bad_verdicts++;
        end
        if (out_data.hit_index !== want.hit_index) begin
          $error("hit_index: expected %0d, got %0d", want.hit_index, out_data.hit_index);
          bad_verdicts++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_load_table();
    test_first_match();
    test_count_limits();
    test_write_then_lookup();
    test_random_sweep();
    test_back_pressure();
    drain_pipe();
    if (bad_verdicts == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
